// File: rtl/palette_gradient_lookup_assert.svh
// Assertion macros shared by the palette gradient lookup RTL.
`ifndef PALETTE_GRADIENT_LOOKUP_ASSERT_SVH
`define PALETTE_GRADIENT_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PGL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pgl assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PGL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pgl assertion failed");

`endif

// File: rtl/pgl_pkg.sv
// Types and constants shared by the palette gradient lookup modules.
package pgl_pkg;

	localparam int IDX_W = 8;
	localparam int RGB_W = 24;
	localparam int CH_W = 8;
	localparam int NUM_CH = 3;
	localparam int WGT_W = 17;
	localparam int REM_W = WGT_W + CH_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FG = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd4;

	typedef struct packed {
		logic       capture;
		logic       setup1;
		logic       setup2;
		logic       setup3;
		logic       mul;
		logic       div;
		logic       chan;
		logic [1:0] ch;
		logic [2:0] bitsel;
		logic       load_out;
	} pgl_cmd_t;

	typedef struct packed {
		logic direct;
	} pgl_status_t;

endpackage

// File: rtl/pgl_store.sv
// Override color memory with per-entry valid flags.
module pgl_store #(
	parameter int ENTRIES = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic                    clr,
	input  logic                    rd_en,
	input  logic [pgl_pkg::IDX_W-1:0] addr,
	input  logic [pgl_pkg::RGB_W-1:0] wdata,
	output logic [pgl_pkg::RGB_W-1:0] rdata_q,
	output logic                    rvalid_q
);
	import pgl_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [RGB_W-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic in_tab;

	assign in_tab = {1'b0, addr} < (IDX_W+1)'(ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en && in_tab) begin
				valid_q[addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= in_tab && valid_q[addr[AW-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && in_tab) begin
			mem[addr[AW-1:0]] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr[AW-1:0]];
		end
	end

endmodule

// File: rtl/pgl_datapath.sv
// Ramp datapath: span setup, weight products and a shared restoring divider.
module pgl_datapath #(
	parameter int ENTRIES = 256
) (
	input  logic                      clk,
	input  pgl_pkg::pgl_cmd_t         cmd,
	input  logic [pgl_pkg::IDX_W-1:0] entry_index,
	input  logic [pgl_pkg::IDX_W-1:0] first_index,
	input  logic [pgl_pkg::IDX_W-1:0] last_index,
	input  logic [pgl_pkg::RGB_W-1:0] background_rgb,
	input  logic [pgl_pkg::RGB_W-1:0] foreground_rgb,
	input  logic                      nonlinear_mode,
	input  logic [pgl_pkg::RGB_W-1:0] ov_rgb,
	input  logic                      ov_valid,
	output pgl_pkg::pgl_status_t      status,
	output logic [pgl_pkg::RGB_W-1:0] result_q,
	output logic                      found_q
);
	import pgl_pkg::*;

	logic [IDX_W-1:0] idx_q, k_q, span_q, nd_q;
	logic [IDX_W-2:0] c_q;
	logic direct_q;
	logic [15:0] m1_q;
	logic [WGT_W-1:0] m2_q, w_q, den_q;
	logic [REM_W-1:0] rem_q;
	logic [CH_W-1:0] q_q, b_q;
	logic neg_q;

	logic in_tab, in_span;
	logic [IDX_W-1:0] span_w, k_w, nd_w, mul_sel, f_w, b_w;
	logic [IDX_W-2:0] c_w;
	logic [15:0] c_prod;
	logic [REM_W-1:0] trial;
	logic [CH_W-1:0] chan_v;

	assign in_tab = {1'b0, idx_q} < (IDX_W+1)'(ENTRIES);
	assign in_span = (last_index >= first_index) && (idx_q >= first_index)
		&& (idx_q <= last_index);
	assign span_w = last_index - first_index;
	assign k_w = idx_q - first_index;
	// floor(span / 3) by reciprocal multiplication, exact for 8-bit spans.
	assign c_prod = 16'(span_w) * 16'd171;
	assign c_w = c_prod[15:9];
	assign nd_w = span_q - IDX_W'(c_q);
	assign mul_sel = (k_q <= IDX_W'(c_q)) ? IDX_W'(k_q * 3) : IDX_W'(c_q * 3);
	assign b_w = background_rgb[CH_W*cmd.ch +: CH_W];
	assign f_w = foreground_rgb[CH_W*cmd.ch +: CH_W];
	assign trial = REM_W'(den_q) << cmd.bitsel;
	assign chan_v = neg_q ? (b_q - q_q - CH_W'(rem_q != '0)) : (b_q + q_q);
	assign status.direct = direct_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= entry_index;
		end
		if (cmd.setup1) begin
			k_q <= k_w;
			span_q <= span_w;
			c_q <= c_w;
			direct_q <= 1'b1;
			result_q <= '0;
			found_q <= 1'b0;
			if (in_tab && ov_valid) begin
				result_q <= ov_rgb;
				found_q <= 1'b1;
			end else if (in_tab && in_span) begin
				found_q <= 1'b1;
				if (span_w == '0) begin
					result_q <= background_rgb;
				end else if (k_w == span_w) begin
					result_q <= foreground_rgb;
				end else begin
					direct_q <= 1'b0;
				end
			end
		end
		if (cmd.setup2) begin
			nd_q <= nd_w;
			m1_q <= 16'(nd_w) * 16'(mul_sel);
			if (k_q <= IDX_W'(c_q)) begin
				m2_q <= '0;
			end else begin
				m2_q <= WGT_W'(k_q - IDX_W'(c_q))
					* WGT_W'(10'(span_q) * 10'd2 - 10'(c_q) * 10'd3);
			end
		end
		if (cmd.setup3) begin
			if (nonlinear_mode) begin
				w_q <= WGT_W'(m1_q) + m2_q;
				den_q <= WGT_W'(span_q) * WGT_W'(nd_q) * WGT_W'(2);
			end else begin
				w_q <= WGT_W'(k_q);
				den_q <= WGT_W'(span_q);
			end
		end
		if (cmd.mul) begin
			neg_q <= f_w < b_w;
			b_q <= b_w;
			q_q <= '0;
			rem_q <= REM_W'(w_q) * REM_W'((f_w < b_w) ? (b_w - f_w) : (f_w - b_w));
		end
		if (cmd.div && rem_q >= trial) begin
			rem_q <= rem_q - trial;
			q_q[cmd.bitsel] <= 1'b1;
		end
		if (cmd.chan) begin
			result_q[CH_W*cmd.ch +: CH_W] <= chan_v;
		end
	end

endmodule

// File: rtl/pgl_ctrl.sv
// Sequencer for lookup setup, per-channel divide and result hand-off.
module pgl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 lookup_beat,
	input  logic                 out_free,
	input  pgl_pkg::pgl_status_t status,
	output pgl_pkg::pgl_cmd_t    cmd,
	output logic                 idle
);
	import pgl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SETUP1, ST_SETUP2, ST_SETUP3, ST_MUL, ST_DIV, ST_CHAN, ST_DONE
	} state_t;

	state_t state_q;
	logic [2:0] cnt_q;
	logic [1:0] ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ch_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (lookup_beat) state_q <= ST_SETUP1;
				end
				ST_SETUP1: state_q <= ST_SETUP2;
				ST_SETUP2: begin
					state_q <= status.direct ? ST_DONE : ST_SETUP3;
				end
				ST_SETUP3: begin
					ch_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= 3'd7;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) state_q <= ST_CHAN;
					else cnt_q <= cnt_q - 3'd1;
				end
				ST_CHAN: begin
					if (ch_q == 2'(NUM_CH - 1)) begin
						state_q <= ST_DONE;
					end else begin
						ch_q <= ch_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign idle = state_q == ST_IDLE;

	always_comb begin
		cmd = '0;
		cmd.capture = (state_q == ST_IDLE) && lookup_beat;
		cmd.setup1 = state_q == ST_SETUP1;
		cmd.setup2 = state_q == ST_SETUP2;
		cmd.setup3 = state_q == ST_SETUP3;
		cmd.mul = state_q == ST_MUL;
		cmd.div = state_q == ST_DIV;
		cmd.chan = state_q == ST_CHAN;
		cmd.ch = ch_q;
		cmd.bitsel = cnt_q;
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

endmodule

// File: rtl/palette_gradient_lookup.sv
// Top level of the palette gradient lookup: ports, registers, output stage.
// Usage:
// Input beats on s_*: s_tuser holds the function (look up, write override,
// clear all overrides), s_tdata holds the entry index and override color.
// A lookup gives one beat on m_*: m_tdata is the color, m_tuser is found.
// Writes and clears give no beat. A lookup answered by an override,
// by the last span entry or a one-entry span, or a miss, goes from
// SETUP1 and SETUP2 straight to DONE. A ramp lookup runs SETUP1 to SETUP3,
// then per color channel a multiply, the shared restoring divider for the
// eight quotient bits and a step that folds the quotient in.
// One item is in work at a time; s_tready is high only while idle.
// The result sits in an output register, so a new item is taken while a
// result still waits; a stalled receiver holds the block only once a second
// result is ready. Configuration writes on cfg_* are taken at any time and
// must only come while the block is idle.
// Reset sets the ramp to 0..255 black to white, linear, and clears all
// override flags; override colors need no clearing.
module palette_gradient_lookup #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // entry_index[7:0], override_rgb[31:8]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // palette_rgb[23:0]
	output logic        m_tuser,  // found
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import pgl_pkg::*;

	logic [IDX_W-1:0] first_index_q, last_index_q;
	logic [RGB_W-1:0] background_rgb_q, foreground_rgb_q;
	logic nonlinear_mode_q;
	logic s_beat, lookup_beat, out_free, idle;
	logic [RGB_W-1:0] ov_rgb, result;
	logic ov_valid, found;
	logic m_tvalid_q;
	logic [RGB_W-1:0] m_tdata_q;
	logic m_tuser_q;
	pgl_cmd_t cmd;
	pgl_status_t status;

	assign cfg_ready = 1'b1;
	assign s_tready = idle;
	assign s_beat = s_tvalid && s_tready;
	assign lookup_beat = s_beat && (s_tuser == FUNC_LOOKUP);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_index_q <= '0;
			last_index_q <= '1;
			background_rgb_q <= '0;
			foreground_rgb_q <= '1;
			nonlinear_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIRST: first_index_q <= cfg_data[IDX_W-1:0];
				CFG_LAST: last_index_q <= cfg_data[IDX_W-1:0];
				CFG_BG: background_rgb_q <= cfg_data;
				CFG_FG: foreground_rgb_q <= cfg_data;
				CFG_MODE: nonlinear_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= result;
			m_tuser_q <= found;
		end
	end

	pgl_store #(.ENTRIES(PALETTE_ENTRIES)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (s_beat && (s_tuser == FUNC_WRITE)),
		.clr      (s_beat && (s_tuser == FUNC_CLEAR)),
		.rd_en    (lookup_beat),
		.addr     (s_tdata[IDX_W-1:0]),
		.wdata    (s_tdata[IDX_W +: RGB_W]),
		.rdata_q  (ov_rgb),
		.rvalid_q (ov_valid)
	);

	pgl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_beat (lookup_beat),
		.out_free    (out_free),
		.status      (status),
		.cmd         (cmd),
		.idle        (idle)
	);

	pgl_datapath #(.ENTRIES(PALETTE_ENTRIES)) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.entry_index    (s_tdata[IDX_W-1:0]),
		.first_index    (first_index_q),
		.last_index     (last_index_q),
		.background_rgb (background_rgb_q),
		.foreground_rgb (foreground_rgb_q),
		.nonlinear_mode (nonlinear_mode_q),
		.ov_rgb         (ov_rgb),
		.ov_valid       (ov_valid),
		.status         (status),
		.result_q       (result),
		.found_q        (found)
	);

`include "palette_gradient_lookup_assert.svh"

	`PGL_ASSERT_IMP(a_load_only_free, cmd.load_out, out_free)
	`PGL_ASSERT_NXT(a_lookup_goes_busy, lookup_beat, !s_tready)
	`PGL_ASSERT_IMP(a_miss_is_black, m_tvalid && !m_tuser, m_tdata == '0)

endmodule

// File: test/palette_gradient_lookup_test.sv
// Self-checking stream testbench for the palette gradient lookup block.
`timescale 1ns / 100ps

module palette_gradient_lookup_test;
	import pgl_pkg::*;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  idx;
		logic [23:0] rgb;
	} beat_t;

	typedef struct packed {
		logic [23:0] color;
		logic        found;
	} color_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	palette_gradient_lookup u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: ramp settings and override table.
	logic [7:0]  ramp_first, ramp_last;
	logic [23:0] bg_rgb, fg_rgb;
	logic        two_slope;
	logic [23:0] ovr_rgb [256];
	logic        ovr_set [256];

	beat_t  pending_beats[$];
	color_t expected_colors[$];
	int     send_idle_pct, recv_idle_pct;
	int     mismatches;
	int     stall_cycles;
	bit     timed_out;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic longint floor_quot(longint n, longint den);
		longint q;
		q = n / den;
		if ((n % den) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function automatic logic [7:0] ramp_value(int sh, longint k, longint span);
		longint b, f, d, num, den, c;
		b = longint'((bg_rgb >> sh) & 24'hFF);
		f = longint'((fg_rgb >> sh) & 24'hFF);
		d = f - b;
		if (!two_slope) begin
			num = k * d;
			den = span;
		end else begin
			c = span / 3;
			if (k <= c) begin
				num = 3 * k * d;
				den = 2 * span;
			end else begin
				num = d * (3 * c * (span - c) + (k - c) * (2 * span - 3 * c));
				den = 2 * span * (span - c);
			end
		end
		return 8'(b + floor_quot(num, den));
	endfunction

	function automatic void predict_beat(beat_t b);
		color_t r;
		longint span, k;
		if (b.func == FUNC_WRITE) begin
			ovr_rgb[b.idx] = b.rgb;
			ovr_set[b.idx] = 1'b1;
			return;
		end
		if (b.func == FUNC_CLEAR) begin
			foreach (ovr_set[i])
				ovr_set[i] = 1'b0;
			return;
		end
		if (b.func != FUNC_LOOKUP)
			return;
		r = '0;
		if (ovr_set[b.idx]) begin
			r.color = ovr_rgb[b.idx];
			r.found = 1'b1;
		end else if (ramp_last >= ramp_first && b.idx >= ramp_first && b.idx <= ramp_last) begin
			span = longint'(ramp_last - ramp_first);
			k = longint'(b.idx - ramp_first);
			r.found = 1'b1;
			if (span == 0)
				r.color = bg_rgb;
			else if (k == span)
				r.color = fg_rgb;
			else
				r.color = {ramp_value(16, k, span), ramp_value(8, k, span), ramp_value(0, k, span)};
		end
		expected_colors.push_back(r);
	endfunction

	// Driver: one beat per handshake, valid held until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				predict_beat({s_tuser, s_tdata[7:0], s_tdata[31:8]});
			if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				beat_t b;
				b = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= b.func;
				s_tdata <= {b.rgb, b.idx};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_colors.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result color=%h found=%b", m_tdata, m_tuser);
				end else begin
					color_t e;
					e = expected_colors.pop_front();
					if (e.color !== m_tdata || e.found !== m_tuser) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected color=%h found=%b, got color=%h found=%b",
								e.color, e.found, m_tdata, m_tuser);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on cycles without any beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 5000)
			timed_out = 1'b1;
	end

	task automatic write_reg(logic [2:0] idx, logic [23:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FIRST: ramp_first = value[7:0];
			CFG_LAST:  ramp_last = value[7:0];
			CFG_BG:    bg_rgb = value;
			CFG_FG:    fg_rgb = value;
			CFG_MODE:  two_slope = value[0];
			default: ;
		endcase
	endtask

	task automatic set_ramp(logic [7:0] f, logic [7:0] l, logic [23:0] bg, logic [23:0] fg,
			logic mode);
		write_reg(CFG_FIRST, 24'(f));
		write_reg(CFG_LAST, 24'(l));
		write_reg(CFG_BG, bg);
		write_reg(CFG_FG, fg);
		write_reg(CFG_MODE, 24'(mode));
	endtask

	task automatic wait_drained();
		while (!timed_out && (pending_beats.size() > 0 || s_tvalid || expected_colors.size() > 0))
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic void queue_beat(logic [1:0] f, logic [7:0] i, logic [23:0] c);
		beat_t b;
		b.func = f;
		b.idx = i;
		b.rgb = c;
		pending_beats.push_back(b);
	endfunction

	// A random phase of mostly lookups around the span, with sparse overrides, clears and unused functions.
	task automatic random_phase(int count);
		int sel;
		logic [7:0] i;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			if ($urandom_range(3) == 0)
				i = 8'($urandom);
			else
				i = 8'(ramp_first + $urandom_range(3) - 1
					+ $urandom_range(8'(ramp_last - ramp_first)));
			if (sel < 78)
				queue_beat(FUNC_LOOKUP, i, 24'($urandom));
			else if (sel < 94)
				queue_beat(FUNC_WRITE, i, 24'($urandom));
			else if (sel < 97)
				queue_beat(FUNC_CLEAR, i, 24'($urandom));
			else
				queue_beat(2'd3, i, 24'($urandom));
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		stall_cycles = 0;
		timed_out = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		ramp_first = 8'd0;
		ramp_last = 8'd255;
		bg_rgb = 24'h000000;
		fg_rgb = 24'hFFFFFF;
		two_slope = 1'b0;
		foreach (ovr_set[i]) begin
			ovr_set[i] = 1'b0;
			ovr_rgb[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset ramp ends and middle, overrides, clear, unused function.
		queue_beat(FUNC_LOOKUP, 8'd0, 24'hFFFFFF);
		queue_beat(FUNC_LOOKUP, 8'd255, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd128, 24'h0);
		queue_beat(FUNC_WRITE, 8'd255, 24'hA5A5A5);
		queue_beat(FUNC_WRITE, 8'd0, 24'hFFFFFF);
		queue_beat(FUNC_LOOKUP, 8'd255, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd0, 24'h0);
		queue_beat(FUNC_CLEAR, 8'd0, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd255, 24'h0);
		queue_beat(2'd3, 8'd7, 24'h123456);
		queue_beat(FUNC_LOOKUP, 8'd7, 24'h0);
		wait_drained();
		// Span of one, span of two, reversed span, and a falling nonlinear ramp.
		set_ramp(8'd40, 8'd40, 24'h123456, 24'hABCDEF, 1'b0);
		queue_beat(FUNC_LOOKUP, 8'd40, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd41, 24'h0);
		wait_drained();
		set_ramp(8'd254, 8'd255, 24'hFF00FF, 24'h00FF00, 1'b1);
		queue_beat(FUNC_LOOKUP, 8'd254, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd255, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd253, 24'h0);
		wait_drained();
		set_ramp(8'd200, 8'd10, 24'h0, 24'hFFFFFF, 1'b0);
		queue_beat(FUNC_LOOKUP, 8'd100, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd10, 24'h0);
		wait_drained();
		set_ramp(8'd0, 8'd255, 24'hFFFFFF, 24'h000000, 1'b1);
		queue_beat(FUNC_LOOKUP, 8'd85, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd86, 24'h0);
		queue_beat(FUNC_LOOKUP, 8'd254, 24'h0);
		wait_drained();

		for (int p = 0; p < 12; p++) begin
			if (p < 4) begin
				send_idle_pct = 16;
				recv_idle_pct = 68;
			end else if (p < 8) begin
				send_idle_pct = 68;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p % 4)
				0: set_ramp(8'($urandom), 8'($urandom), 24'($urandom), 24'($urandom),
					1'($urandom));
				1: set_ramp(8'($urandom_range(20)), 8'(235 + $urandom_range(20)),
					24'($urandom), 24'($urandom), 1'($urandom));
				2: begin
					logic [7:0] f;
					f = 8'($urandom_range(250));
					set_ramp(f, 8'(f + $urandom_range(5)), 24'($urandom), 24'($urandom),
						1'($urandom));
				end
				default: set_ramp(8'd0, 8'd255, 24'h0, 24'hFFFFFF, p[2]);
			endcase
			random_phase(140);
			if (timed_out)
				break;
		end

		if (timed_out) begin
			$display("Regression FAIL");
		end else if (mismatches == 0 && expected_colors.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
